// ===== hdl/btmx_pkg.sv =====
// ============================================================================
// btmx_pkg - shared types and constants for the binary trie min-xor block
// Holds the transfer payload structs, command and status codes, the
// sequencer state type and the edge unit operation and flag types.
// ============================================================================
package btmx_pkg;

  // Payload field widths
  localparam int KEY_W    = 60;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Stored key total is a fixed 16-bit counter
  localparam int TOTAL_W = 16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } btmx_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]    min_xor;
    logic [STATUS_W-1:0] status;
  } btmx_res_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OPEN,
    S_CHECK,
    S_FIT,
    S_REOPEN,
    S_UPDATE,
    S_QUERY,
    S_REPORT
  } state_t;

  // Edge unit operations
  typedef enum logic [1:0] {
    EOP_LOOK,
    EOP_QUERY,
    EOP_INC,
    EOP_DEC
  } edge_op_t;

  // Edge unit status toward the sequencer
  typedef struct packed {
    logic flipped;
    logic cnt_zero;
    logic cnt_full;
    logic child_null;
  } edge_flags_t;

endpackage

// ===== hdl/btmx_ram.sv =====
// ============================================================================
// btmx_ram - generic single-write, single-read RAM
// One write port and one read port, read data registered. A read of the
// address written in the same cycle returns the old contents.
// ============================================================================
module btmx_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/btmx_edge.sv =====
// ============================================================================
// btmx_edge - shared edge unit of the trie walk
// Takes one node row (child and count for both edges), picks the edge for
// the key bit, reports its flags, and builds the updated row for an insert
// (allocate and increment) or a remove (decrement).
// ============================================================================
module btmx_edge #(
  parameter int NODE_W  = 12,
  parameter int COUNT_W = 16
) (
  input  logic [2*(NODE_W+COUNT_W)-1:0] row,
  input  logic                          bit_in,
  input  btmx_pkg::edge_op_t            op,
  input  logic [NODE_W-1:0]             free_node,
  output logic [2*(NODE_W+COUNT_W)-1:0] row_new,
  output logic [NODE_W-1:0]             child,
  output btmx_pkg::edge_flags_t         flags
);
  import btmx_pkg::*;

  localparam int SIDE_W = NODE_W + COUNT_W;

  logic [NODE_W-1:0]  child_a [2];
  logic [COUNT_W-1:0] cnt_a   [2];
  logic               side;
  logic [NODE_W-1:0]  child_new;
  logic [COUNT_W-1:0] cnt_new;

  // Split the row into both of its edges
  always_comb begin
    for (int s = 0; s < 2; s++) begin
      child_a[s] = row[s*SIDE_W+COUNT_W +: NODE_W];
      cnt_a[s]   = row[s*SIDE_W +: COUNT_W];
    end
  end

  // Pick the edge: a query steers to the other edge when this one is empty
  always_comb begin
    if (op == EOP_QUERY && cnt_a[bit_in] == '0) begin
      side = ~bit_in;
    end else begin
      side = bit_in;
    end
  end

  assign flags.flipped    = (side != bit_in);
  assign flags.cnt_zero   = (cnt_a[side] == '0);
  assign flags.cnt_full   = &cnt_a[side];
  assign flags.child_null = (child_a[side] == '0);

  // Allocate a fresh node on insert where the edge has no child
  assign child_new = (op == EOP_INC && flags.child_null) ? free_node : child_a[side];
  assign child     = child_new;

  // Count update for the chosen edge
  always_comb begin
    case (op)
      EOP_INC: cnt_new = cnt_a[side] + 1'b1;
      EOP_DEC: cnt_new = cnt_a[side] - 1'b1;
      default: cnt_new = cnt_a[side];
    endcase
  end

  // Rebuild the row with the chosen edge replaced
  always_comb begin
    row_new = row;
    row_new[side*SIDE_W +: SIDE_W] = {child_new, cnt_new};
  end

endmodule

// ===== hdl/binary_trie_min_xor_top.sv =====
// ============================================================================
// binary_trie_min_xor_top - multiset of keys in a binary trie, min-xor query
// Insert, remove or query one key per command. Nodes live in one RAM row
// each (both children, both edge counts) and are walked MSB first by a small
// sequencer around one shared edge unit.
// ============================================================================
//
//  Channel   Signals                       Handshake
//  --------  ----------------------------  ---------------------------------
//  command   start, busy, request          transfer when start && !busy
//  result    done, result                  done high one cycle, no stall
//
//  Walks: one RAM read per trie level. A query walks the trie once; a
//  remove or an insert walks it twice (check walk, then update walk), an
//  insert with a capacity compare between the two. Rejected items end
//  early, as do an empty-set query and an insert at full total.
//  Reset: a clearing pass writes NODE_COUNT rows, one per cycle, with busy
//  high; commands are taken after it.
//  Stalls: the receiver cannot stall; the block takes no command while busy.
// ============================================================================
module binary_trie_min_xor_top #(
  parameter int KEY_BITS   = 60,
  parameter int NODE_COUNT = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  btmx_pkg::btmx_req_t  request,
  output logic                 done,
  output btmx_pkg::btmx_res_t  result
);
  import btmx_pkg::*;

  localparam int NODE_W   = $clog2(NODE_COUNT);
  localparam int ROW_W    = 2 * (NODE_W + COUNT_BITS);
  localparam int LVL_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int NEED_W   = LVL_W + 1;
  localparam int SUM_W    = NODE_W + NEED_W + 2;
  localparam logic [LVL_W-1:0]  LAST_LVL = LVL_W'(KEY_BITS - 1);
  localparam logic [NODE_W-1:0] LAST_ROW = NODE_W'(NODE_COUNT - 1);

  state_t              state, state_next;
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] key_sh;
  logic [LVL_W-1:0]    lvl;
  logic [NODE_W-1:0]   node;
  logic [KEY_BITS-1:0] acc;
  logic                stopped;
  logic [NEED_W-1:0]   need;
  logic [NODE_W:0]     next_free;
  logic [TOTAL_W-1:0]  total;
  logic [NODE_W-1:0]   clr_addr;
  btmx_res_t           res_r;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;
  logic [NODE_W-1:0]   ram_raddr;
  logic [ROW_W-1:0]    ram_rdata;

  edge_op_t            eop;
  edge_flags_t         eflags;
  logic [NODE_W-1:0]   echild;
  logic [ROW_W-1:0]    erow_new;
  logic                ebit;
  logic                at_last;
  logic                clr_last;
  logic                no_room;
  logic                qflag;
  logic [KEY_BITS-1:0] acc_shift;

  // Node store
  btmx_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared edge unit
  btmx_edge #(
    .NODE_W (NODE_W),
    .COUNT_W(COUNT_BITS)
  ) u_edge (
    .row      (ram_rdata),
    .bit_in   (ebit),
    .op       (eop),
    .free_node(next_free[NODE_W-1:0]),
    .row_new  (erow_new),
    .child    (echild),
    .flags    (eflags)
  );

  assign ebit      = key_sh[KEY_BITS-1];
  assign at_last   = (lvl == '0);
  assign clr_last  = (clr_addr == LAST_ROW);
  assign no_room   = (SUM_W'(next_free) + SUM_W'(need)) > SUM_W'(NODE_COUNT);
  assign qflag     = eflags.flipped & ~stopped;
  assign acc_shift = (acc << 1) | KEY_BITS'(qflag);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_INSERT: state_next = (total >= TOTAL_MAX) ? S_REPORT : S_OPEN;
            CMD_REMOVE: state_next = S_OPEN;
            CMD_QUERY:  state_next = (total == '0) ? S_REPORT : S_OPEN;
            default:    state_next = S_REPORT;
          endcase
        end
      end
      S_OPEN: begin
        state_next = (cmd_r == CMD_QUERY) ? S_QUERY : S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_INSERT) begin
          if (eflags.cnt_full) begin
            state_next = S_REPORT;
          end else if (eflags.child_null || at_last) begin
            state_next = S_FIT;
          end
        end else begin
          if (eflags.child_null || eflags.cnt_zero) begin
            state_next = S_REPORT;
          end else if (at_last) begin
            state_next = S_REOPEN;
          end
        end
      end
      S_FIT: begin
        state_next = no_room ? S_REPORT : S_REOPEN;
      end
      S_REOPEN: begin
        state_next = S_UPDATE;
      end
      S_UPDATE, S_QUERY: begin
        if (at_last) begin
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node;
    ram_wdata = erow_new;
    ram_raddr = node;
    eop       = EOP_LOOK;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_OPEN, S_REOPEN: begin
        ram_raddr = '0;
      end
      S_CHECK: begin
        ram_raddr = echild;
      end
      S_UPDATE: begin
        eop       = (cmd_r == CMD_INSERT) ? EOP_INC : EOP_DEC;
        ram_we    = 1'b1;
        ram_raddr = echild;
      end
      S_QUERY: begin
        eop       = EOP_QUERY;
        ram_raddr = echild;
      end
      default: begin
        eop = EOP_LOOK;
      end
    endcase
  end

  assign busy   = (state != S_IDLE);
  assign done   = (state == S_REPORT);
  assign result = res_r;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Store bookkeeping: clearing pass, free node pointer, key total
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      next_free <= (NODE_W+1)'(1);
      total     <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == S_UPDATE && cmd_r == CMD_INSERT && eflags.child_null) begin
        next_free <= next_free + 1'b1;
      end
      if (state == S_UPDATE && at_last) begin
        if (cmd_r == CMD_INSERT) begin
          total <= total + 1'b1;
        end else if (total != '0) begin
          total <= total - 1'b1;
        end
      end
    end
  end

  // Walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r         <= request.command;
          key_r         <= KEY_BITS'(request.key);
          key_sh        <= KEY_BITS'(request.key);
          lvl           <= LAST_LVL;
          node          <= '0;
          acc           <= '0;
          stopped       <= 1'b0;
          need          <= '0;
          res_r.min_xor <= '0;
          res_r.status  <= (request.command == CMD_INSERT && total >= TOTAL_MAX) ? STAT_FULL :
                           (request.command == CMD_QUERY && total == '0) ? STAT_EMPTY :
                           STAT_OK;
        end
      end
      S_CHECK: begin
        if (cmd_r == CMD_INSERT) begin
          if (eflags.cnt_full) begin
            res_r.status <= STAT_FULL;
          end else if (eflags.child_null) begin
            need <= NEED_W'(lvl) + 1'b1;
          end else if (!at_last) begin
            node   <= echild;
            key_sh <= key_sh << 1;
            lvl    <= lvl - 1'b1;
          end
        end else begin
          if (eflags.child_null || eflags.cnt_zero) begin
            res_r.status <= STAT_ABSENT;
          end else begin
            node   <= echild;
            key_sh <= key_sh << 1;
            lvl    <= lvl - 1'b1;
          end
        end
      end
      S_FIT: begin
        if (no_room) begin
          res_r.status <= STAT_FULL;
        end
      end
      S_REOPEN: begin
        key_sh <= key_r;
        lvl    <= LAST_LVL;
        node   <= '0;
      end
      S_UPDATE: begin
        node   <= echild;
        key_sh <= key_sh << 1;
        lvl    <= lvl - 1'b1;
      end
      S_QUERY: begin
        acc     <= acc_shift;
        stopped <= stopped | eflags.child_null;
        node    <= echild;
        key_sh  <= key_sh << 1;
        lvl     <= lvl - 1'b1;
        if (at_last) begin
          res_r.min_xor <= KEY_W'(acc_shift);
        end
      end
      default: begin
        node <= node;
      end
    endcase
  end

`ifndef SYNTHESIS
  // One result per command; done is never high in consecutive cycles
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The free pointer never passes the node count
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= (NODE_W+1)'(NODE_COUNT))
    else $error("node allocation beyond the store");

  // RAM is written only by the clearing pass or the update walk
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_UPDATE))
    else $error("node store written outside clear or update");

  // Key total moves only at the end of an update walk
  a_total_move: assert property (@(posedge clk) disable iff (rst)
    !$stable(total) |-> ($past(state) == S_UPDATE && $past(at_last)))
    else $error("key total changed outside a committed update");

  // A query on an empty set reports empty on the next cycle
  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && request.command == CMD_QUERY && total == '0)
      |=> (done && result.status == STAT_EMPTY))
    else $error("empty-set query not reported as empty");
`endif

endmodule
